// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the lighting pipeline modules.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CHECK_IMPLIES(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

`define CHECK_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== rtl/core/wlvl_pkg.sv =====
package wlvl_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int BONE_IDX_W = 7;
    localparam int BONE_LIMIT = 1 << BONE_IDX_W;
    localparam int VEC_W      = 16;
    localparam int PROD_W     = 2 * VEC_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int WRAP_SHIFT = 2 * FRAC_BITS - 8;
    localparam int NUM_W      = 12 + WRAP_SHIFT;
    localparam int SCALED_W   = 8 + NUM_W;
    localparam int DIVIDEND_W = SCALED_W - WRAP_SHIFT;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 3;

    localparam logic signed [SUM_W-1:0] COS_ONE = SUM_W'(1) <<< (2 * FRAC_BITS);
    localparam logic [11:0] WRAP_ONE = 12'd256;

    localparam logic OP_LIGHT = 1'b0;
    localparam logic OP_LOAD  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_AMBIENT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHADE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RED     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE    = 3'd5;

    typedef struct packed {
        logic                    opcode;
        logic [BONE_IDX_W-1:0]   bone_index;
        logic                    flat_shade;
        logic signed [VEC_W-1:0] vec_x;
        logic signed [VEC_W-1:0] vec_y;
        logic signed [VEC_W-1:0] vec_z;
    } request_t;

    typedef struct packed {
        logic [7:0] intensity;
        logic [8:0] red;
        logic [8:0] green;
        logic [8:0] blue;
    } result_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [VEC_W-1:0] z;
    } vec_t;

    // Wrap holds the effective factor, never below one.
    typedef struct packed {
        logic [7:0]  ambient;
        logic [7:0]  shade;
        logic [11:0] wrap;
        logic [8:0]  red;
        logic [8:0]  green;
        logic [8:0]  blue;
    } cfg_t;

    typedef struct packed {
        logic                  valid;
        logic                  flat;
        logic                  zero;
        logic [DIVIDEND_W-1:0] dividend;
    } div_req_t;

    typedef struct packed {
        logic       valid;
        logic       flat;
        logic       zero;
        logic [7:0] quot;
    } div_rsp_t;

endpackage

// ===== rtl/core/wrap_lambert_vertex_lighting_top.sv =====
// done rises once a light request has passed the dot-product, divider, level and result
// registers, and its result is valid while done is high.
// Throughput: one request per cycle; busy stays low, loads and lights may alternate freely.
// A load with an in-range bone index updates the bone table at its accepting edge and produces no result.
// Reset clears configuration to defaults and empties the pipeline; the bone
// table is not cleared and must be loaded before use. The receiver cannot stall.
`include "assert_macros.svh"

module wrap_lambert_vertex_lighting_top
    import wlvl_pkg::*;
#(
    parameter int BONE_COUNT = 128
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  request_t              request,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  done,
    output result_t               result
);

    localparam int TABLE_DEPTH   = (BONE_COUNT < BONE_LIMIT) ? BONE_COUNT : BONE_LIMIT;
    localparam int LIGHT_LATENCY = 12;

    logic        accept, light_accept, load_accept, in_range;
    logic [7:0]  ambient_reg, ambient_next, shade_reg, shade_next;
    logic [11:0] wrap_reg, wrap_next;
    logic [8:0]  red_reg, red_next, green_reg, green_next, blue_reg, blue_next;
    cfg_t        cfg;
    vec_t        req_vec, table_rdata;
    div_req_t    div_req;
    div_rsp_t    div_rsp;

    assign busy         = 1'b0;
    assign accept       = start && !busy;
    assign in_range     = 32'(request.bone_index) < BONE_COUNT;
    assign light_accept = accept && (request.opcode == OP_LIGHT);
    assign load_accept  = accept && (request.opcode == OP_LOAD) && in_range;

    always_comb
    begin
        ambient_next = ambient_reg;
        shade_next   = shade_reg;
        wrap_next    = wrap_reg;
        red_next     = red_reg;
        green_next   = green_reg;
        blue_next    = blue_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_AMBIENT: ambient_next = cfg_data[7:0];
                REG_SHADE:   shade_next   = cfg_data[7:0];
                REG_WRAP:    wrap_next    = (cfg_data < WRAP_ONE) ? WRAP_ONE : cfg_data;
                REG_RED:     red_next     = cfg_data[8:0];
                REG_GREEN:   green_next   = cfg_data[8:0];
                REG_BLUE:    blue_next    = cfg_data[8:0];
                default:     ambient_next = ambient_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ambient_reg <= 8'd32;
            shade_reg   <= 8'd192;
            wrap_reg    <= 12'd384;
            red_reg     <= 9'd256;
            green_reg   <= 9'd256;
            blue_reg    <= 9'd256;
        end
        else
        begin
            ambient_reg <= ambient_next;
            shade_reg   <= shade_next;
            wrap_reg    <= wrap_next;
            red_reg     <= red_next;
            green_reg   <= green_next;
            blue_reg    <= blue_next;
        end
    end

    assign cfg.ambient = ambient_reg;
    assign cfg.shade   = shade_reg;
    assign cfg.wrap    = wrap_reg;
    assign cfg.red     = red_reg;
    assign cfg.green   = green_reg;
    assign cfg.blue    = blue_reg;

    assign req_vec.x = request.vec_x;
    assign req_vec.y = request.vec_y;
    assign req_vec.z = request.vec_z;

    wlvl_table #(
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (load_accept),
        .addr  (request.bone_index),
        .wdata (req_vec),
        .rdata (table_rdata)
    );

    wlvl_dot u_dot (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (light_accept),
        .in_flat  (request.flat_shade),
        .in_range (in_range),
        .normal   (req_vec),
        .light    (table_rdata),
        .div_req  (div_req)
    );

    wlvl_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .wrap    (wrap_reg),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    wlvl_out u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .div_rsp (div_rsp),
        .done    (done),
        .result  (result)
    );

    `CHECK_IMPLIES(a_done_source, done, $past(light_accept, LIGHT_LATENCY), "result without a matching light request")

endmodule

// ===== rtl/core/wlvl_table.sv =====
module wlvl_table
    import wlvl_pkg::*;
#(
    parameter int DEPTH = 128
)
(
    input  logic                  clk,
    input  logic                  we,
    input  logic [BONE_IDX_W-1:0] addr,
    input  vec_t                  wdata,
    output vec_t                  rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    vec_t mem [DEPTH];
    vec_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr[AW-1:0]] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[addr[AW-1:0]];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/wlvl_dot.sv =====
module wlvl_dot
    import wlvl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     in_valid,
    input  logic     in_flat,
    input  logic     in_range,
    input  vec_t     normal,
    input  vec_t     light,
    output div_req_t div_req
);

    logic s1_valid_reg, s1_flat_reg, s1_range_reg;
    vec_t s1_normal_reg;

    logic s2_valid_reg, s2_flat_reg;
    logic signed [PROD_W-1:0] s2_px_reg, s2_py_reg, s2_pz_reg;
    logic signed [PROD_W-1:0] s2_px_next, s2_py_next, s2_pz_next;
    vec_t light_sel;

    logic s3_valid_reg, s3_flat_reg;
    logic signed [SUM_W-1:0] s3_cos_reg, s3_cos_next, dot_sum;

    logic s4_valid_reg, s4_flat_reg, s4_pos_reg, s4_pos_next;
    logic [NUM_W-1:0] s4_num_reg;
    logic signed [SUM_W-1:0] num_full, wrap_offset;

    logic s5_valid_reg, s5_flat_reg, s5_zero_reg;
    logic [SCALED_W-1:0] s5_scaled_reg, s5_scaled_next;

    logic s6_valid_reg, s6_flat_reg, s6_zero_reg, s6_zero_next;
    logic [DIVIDEND_W-1:0] s6_dividend_reg;
    logic [SCALED_W-1:0] scaled_dec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    // A bone outside the table lights with a zero vector.
    always_comb
    begin
        light_sel = s1_range_reg ? light : '0;
        s2_px_next = PROD_W'(s1_normal_reg.x) * PROD_W'(light_sel.x);
        s2_py_next = PROD_W'(s1_normal_reg.y) * PROD_W'(light_sel.y);
        s2_pz_next = PROD_W'(s1_normal_reg.z) * PROD_W'(light_sel.z);
    end

    always_comb
    begin
        dot_sum = SUM_W'(s2_px_reg) + SUM_W'(s2_py_reg) + SUM_W'(s2_pz_reg);
        s3_cos_next = (dot_sum > COS_ONE) ? COS_ONE : dot_sum;
    end

    always_comb
    begin
        wrap_offset = SUM_W'(cfg.wrap - WRAP_ONE) <<< WRAP_SHIFT;
        num_full = s3_cos_reg + wrap_offset;
        s4_pos_next = !num_full[SUM_W-1] && (num_full != '0);
    end

    assign s5_scaled_next = SCALED_W'(cfg.shade) * SCALED_W'(s4_num_reg);

    always_comb
    begin
        scaled_dec = s5_scaled_reg - SCALED_W'(1);
        s6_zero_next = s5_zero_reg || (s5_scaled_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        s1_flat_reg     <= in_flat;
        s1_range_reg    <= in_range;
        s1_normal_reg   <= normal;
        s2_flat_reg     <= s1_flat_reg;
        s2_px_reg       <= s2_px_next;
        s2_py_reg       <= s2_py_next;
        s2_pz_reg       <= s2_pz_next;
        s3_flat_reg     <= s2_flat_reg;
        s3_cos_reg      <= s3_cos_next;
        s4_flat_reg     <= s3_flat_reg;
        s4_pos_reg      <= s4_pos_next;
        s4_num_reg      <= num_full[NUM_W-1:0];
        s5_flat_reg     <= s4_flat_reg;
        s5_zero_reg     <= !s4_pos_reg;
        s5_scaled_reg   <= s5_scaled_next;
        s6_flat_reg     <= s5_flat_reg;
        s6_zero_reg     <= s6_zero_next;
        s6_dividend_reg <= scaled_dec[SCALED_W-1:WRAP_SHIFT];
    end

    assign div_req.valid    = s6_valid_reg;
    assign div_req.flat     = s6_flat_reg;
    assign div_req.zero     = s6_zero_reg;
    assign div_req.dividend = s6_dividend_reg;

endmodule

// ===== rtl/core/wlvl_div.sv =====
module wlvl_div
    import wlvl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [11:0] wrap,
    input  div_req_t    div_req,
    output div_rsp_t    div_rsp
);

    localparam int QUOT_W = 8;
    localparam int STEPS  = 2;
    localparam int STAGES = QUOT_W / STEPS;

    logic                  valid_reg     [STAGES];
    logic                  flat_reg      [STAGES];
    logic                  zero_reg      [STAGES];
    logic [DIVIDEND_W-1:0] rem_reg       [STAGES];
    logic [QUOT_W-1:0]     quot_reg      [STAGES];
    logic [DIVIDEND_W-1:0] rem_next      [STAGES];
    logic [QUOT_W-1:0]     quot_next     [STAGES];

    for (genvar g = 0; g < STAGES; g++)
    begin : g_stage
        logic                  valid_in, flat_in, zero_in;
        logic [DIVIDEND_W-1:0] rem_in;
        logic [QUOT_W-1:0]     quot_in;

        if (g == 0)
        begin : g_first
            assign valid_in = div_req.valid;
            assign flat_in  = div_req.flat;
            assign zero_in  = div_req.zero;
            assign rem_in   = div_req.dividend;
            assign quot_in  = '0;
        end
        else
        begin : g_rest
            assign valid_in = valid_reg[g-1];
            assign flat_in  = flat_reg[g-1];
            assign zero_in  = zero_reg[g-1];
            assign rem_in   = rem_reg[g-1];
            assign quot_in  = quot_reg[g-1];
        end

        // Restoring division, two quotient bits per stage, most significant first.
        always_comb
        begin
            logic [DIVIDEND_W-1:0] rem_work;
            logic [DIVIDEND_W-1:0] trial;
            logic [QUOT_W-1:0]     quot_work;
            int                    k;
            rem_work  = rem_in;
            quot_work = quot_in;
            for (int s = 0; s < STEPS; s++)
            begin
                k = QUOT_W - 1 - g * STEPS - s;
                trial = DIVIDEND_W'(wrap) << k;
                if (rem_work >= trial)
                begin
                    rem_work = rem_work - trial;
                    quot_work[3'(k)] = 1'b1;
                end
            end
            rem_next[g]  = rem_work;
            quot_next[g] = quot_work;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else
            begin
                valid_reg[g] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            flat_reg[g] <= flat_in;
            zero_reg[g] <= zero_in;
            rem_reg[g]  <= rem_next[g];
            quot_reg[g] <= quot_next[g];
        end
    end

    assign div_rsp.valid = valid_reg[STAGES-1];
    assign div_rsp.flat  = flat_reg[STAGES-1];
    assign div_rsp.zero  = zero_reg[STAGES-1];
    assign div_rsp.quot  = quot_reg[STAGES-1];

endmodule

// ===== rtl/core/wlvl_out.sv =====
`include "assert_macros.svh"

module wlvl_out
    import wlvl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  div_rsp_t div_rsp,
    output logic     done,
    output result_t  result
);

    logic       lvl_valid_reg;
    logic [7:0] lvl_reg, lvl_next;
    logic [8:0] shade_drop, lit_sum, flat_sum;
    logic [9:0] shade_x4;
    logic [17:0] flat_scaled;

    logic       done_reg;
    result_t    result_reg, result_next;

    // The subtracted shade term is the rounded-up quotient; four fifths of the
    // shade level uses a reciprocal multiply that is exact over this range.
    always_comb
    begin
        shade_drop  = div_rsp.zero ? 9'd0 : (9'(div_rsp.quot) + 9'd1);
        lit_sum     = 9'(cfg.ambient) + 9'(cfg.shade) - shade_drop;
        shade_x4    = {cfg.shade, 2'b00};
        flat_scaled = 18'(shade_x4) * 18'd205;
        flat_sum    = 9'(cfg.ambient) + 9'(flat_scaled[17:10]);
        if (div_rsp.flat)
        begin
            lvl_next = flat_sum[8] ? 8'd255 : flat_sum[7:0];
        end
        else
        begin
            lvl_next = lit_sum[8] ? 8'd255 : lit_sum[7:0];
        end
    end

    always_comb
    begin
        logic [16:0] red_full, green_full, blue_full;
        red_full   = 17'(lvl_reg) * 17'(cfg.red);
        green_full = 17'(lvl_reg) * 17'(cfg.green);
        blue_full  = 17'(lvl_reg) * 17'(cfg.blue);
        result_next.intensity = lvl_reg;
        result_next.red       = red_full[16:8];
        result_next.green     = green_full[16:8];
        result_next.blue      = blue_full[16:8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            lvl_valid_reg <= div_rsp.valid;
            done_reg      <= lvl_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg    <= lvl_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `CHECK_IMPLIES(a_floor_ambient, done, result.intensity >= $past(cfg.ambient, 2), "intensity fell below the ambient level")
    `CHECK_IMPLIES(a_red_bound, done && ($past(cfg.red) <= 9'd256), result.red <= 9'(result.intensity), "red channel exceeds intensity at unit gain or below")

endmodule
